>>> hw/rtl/csl_pkg.sv
// Shared types and constants of the C subset lexer.
// Used by c_subset_lexer, its port checker and the testbench; depends on nothing else.
package csl_pkg;

    localparam int OUT_BITS = 20;
    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

    // token kinds
    localparam logic [2:0] KIND_RES   = 3'd0;
    localparam logic [2:0] KIND_IDENT = 3'd1;
    localparam logic [2:0] KIND_NUM   = 3'd2;
    localparam logic [2:0] KIND_END   = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    // keyword indexes
    localparam logic [2:0] KW_NONE   = 3'd0;
    localparam logic [2:0] KW_RETURN = 3'd1;
    localparam logic [2:0] KW_IF     = 3'd2;
    localparam logic [2:0] KW_ELSE   = 3'd3;
    localparam logic [2:0] KW_FOR    = 3'd4;
    localparam logic [2:0] KW_WHILE  = 3'd5;

    // keyword text, first character in the top byte
    localparam logic [47:0] TXT_RETURN = 48'h72_65_74_75_72_6E;
    localparam logic [47:0] TXT_IF     = 48'h69_66_00_00_00_00;
    localparam logic [47:0] TXT_ELSE   = 48'h65_6C_73_65_00_00;
    localparam logic [47:0] TXT_FOR    = 48'h66_6F_72_00_00_00;
    localparam logic [47:0] TXT_WHILE  = 48'h77_68_69_6C_65_00;

    localparam logic [63:0] NUM_LIMIT = 64'h1999_9999_9999_9999;  // all ones / 10

    // tdata layout of a result item
    localparam int TDATA_BITS = 128;

    typedef struct packed {
        logic [2:0]          kind;
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] len;
        logic [63:0]         num;
        logic [15:0]         op;
        logic [2:0]          kw;
        logic                last;
    } result_t;

endpackage

>>> hw/rtl/c_subset_lexer.sv
// Top level of the C subset lexer: byte classification, token state and result queue.
// Depends on csl_pkg.
//
// The lexer takes one text byte per cycle on the s_ channel and sends tokens on the
// m_ channel, one result item per cycle while m_tready is high, in the order they
// complete. Each byte is handled in the cycle it is accepted; its tokens (none, one or
// two) land in a four-entry result queue. s_tready is high while the queue has room for
// two items, so bytes flow at one per cycle whenever the sink keeps up; a byte that
// closes one token and emits another pushes two items, and the queue absorbs that. A
// zero byte ends the text: it emits an end token and restarts the position at zero.
// m_tuser carries the token kind, and m_tlast marks the final result item caused by
// one input byte.
module c_subset_lexer
    import csl_pkg::*;
#(
    parameter int POSITION_BITS = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // [19:0] start_offset, [39:20] token_length,
                                             // [103:40] number_value,
                                             // [119:104] operator_text,
                                             // [122:120] keyword_index
    output logic [2:0]            m_tuser,   // [2:0] token_kind
    output logic                  m_tlast    // last_of_step
);

    localparam int P = POSITION_BITS;
    localparam int EXT_W = (P > OUT_BITS) ? P : OUT_BITS;
    localparam logic [P-1:0] POS_MAX = '1;
    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_NUM   = 3'd1;
    localparam logic [2:0] MODE_IDENT = 3'd2;
    localparam logic [2:0] MODE_OP    = 3'd3;
    localparam logic [2:0] MODE_ERR   = 3'd4;

    logic [2:0]   mode_reg, mode_next;
    logic [P-1:0] pos_reg, pos_next;
    logic [P-1:0] start_reg, start_next;
    logic [P-1:0] len_reg, len_next;
    logic [63:0]  acc_reg, acc_next;
    logic [47:0]  head_reg, head_next;
    logic         too_long_reg, too_long_next;
    logic [7:0]   pend_reg, pend_next;

    result_t      fifo_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic [7:0] c;
    logic is_digit, is_letter, is_space, is_punct, is_lead;
    logic s_accept, m_accept;
    logic used;
    logic e0_valid, e1_valid;
    result_t e0, e1, res_a;
    logic [1:0] push_n;
    logic [3:0] digit;
    logic [63:0] acc_x10;
    logic [2:0] kw_hit;

    function automatic logic [OUT_BITS-1:0] clamp_out(input logic [P-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return (ext > EXT_W'(OUT_MAX)) ? OUT_MAX : ext[OUT_BITS-1:0];
    endfunction

    function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
        return (v == POS_MAX) ? v : v + P'(1);
    endfunction

    assign c         = s_tdata;
    assign is_digit  = (c >= "0") && (c <= "9");
    assign is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    assign is_space  = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    assign is_punct  = ((c >= 8'd33) && (c <= 8'd47)) || ((c >= 8'd58) && (c <= 8'd64)) ||
                       ((c >= 8'd91) && (c <= 8'd96)) || ((c >= 8'd123) && (c <= 8'd126));
    assign is_lead   = (c == "=") || (c == "!") || (c == "<") || (c == ">");
    assign digit     = 4'(c - "0");
    assign acc_x10   = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0} + 64'(digit);

    assign s_tready  = (count_reg <= CNT_W'(DEPTH - 2));
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = (count_reg != '0);
    assign m_accept  = m_tvalid && m_tready;

    // keyword match of the identifier that is open
    always_comb begin
        kw_hit = KW_NONE;
        if (!too_long_reg) begin
            if      (len_reg == P'(6) && head_reg == TXT_RETURN) kw_hit = KW_RETURN;
            else if (len_reg == P'(2) && head_reg == TXT_IF)     kw_hit = KW_IF;
            else if (len_reg == P'(4) && head_reg == TXT_ELSE)   kw_hit = KW_ELSE;
            else if (len_reg == P'(3) && head_reg == TXT_FOR)    kw_hit = KW_FOR;
            else if (len_reg == P'(5) && head_reg == TXT_WHILE)  kw_hit = KW_WHILE;
        end
    end

    always_comb begin
        mode_next     = mode_reg;
        pos_next      = sat_inc(pos_reg);
        start_next    = start_reg;
        len_next      = len_reg;
        acc_next      = acc_reg;
        head_next     = head_reg;
        too_long_next = too_long_reg;
        pend_next     = pend_reg;
        used          = 1'b0;
        e0_valid      = 1'b0;
        e1_valid      = 1'b0;
        e0            = '0;
        e1            = '0;

        // close or extend the token that is open
        unique case (mode_reg)
            MODE_ERR: begin
                used = (c != 8'd0);
            end
            MODE_NUM: begin
                if (is_digit) begin
                    if (acc_reg > NUM_LIMIT || (acc_reg == NUM_LIMIT && digit > 4'd5)) begin
                        acc_next = '1;
                    end else begin
                        acc_next = acc_x10;
                    end
                    len_next = sat_inc(len_reg);
                    used     = 1'b1;
                end else begin
                    e0_valid  = 1'b1;
                    e0.kind   = KIND_NUM;
                    e0.start  = clamp_out(start_reg);
                    e0.len    = clamp_out(len_reg);
                    e0.num    = acc_reg;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_IDENT: begin
                if (is_letter || is_digit) begin
                    if (len_reg < P'(6)) begin
                        for (int i = 0; i < 6; i++) begin
                            if (len_reg == P'(i)) head_next[47-8*i -: 8] = c;
                        end
                    end else begin
                        too_long_next = 1'b1;
                    end
                    len_next = sat_inc(len_reg);
                    used     = 1'b1;
                end else begin
                    e0_valid  = 1'b1;
                    e0.kind   = (kw_hit != KW_NONE) ? KIND_RES : KIND_IDENT;
                    e0.start  = clamp_out(start_reg);
                    e0.len    = clamp_out(len_reg);
                    e0.kw     = kw_hit;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_OP: begin
                e0_valid = 1'b1;
                e0.kind  = KIND_RES;
                e0.start = clamp_out(start_reg);
                if (c == "=") begin
                    e0.len = OUT_BITS'(2);
                    e0.op  = {pend_reg, c};
                    used   = 1'b1;
                end else begin
                    e0.len = OUT_BITS'(1);
                    e0.op  = {pend_reg, 8'd0};
                end
                pend_next = '0;
                mode_next = MODE_IDLE;
            end
            default: begin
            end
        endcase

        // start a new token with a byte that was not taken above
        if (!used) begin
            if (c == 8'd0) begin
                e1_valid      = 1'b1;
                e1.kind       = KIND_END;
                e1.start      = clamp_out(pos_reg);
                mode_next     = MODE_IDLE;
                pos_next      = '0;
                start_next    = '0;
                len_next      = '0;
                acc_next      = '0;
                head_next     = '0;
                too_long_next = 1'b0;
                pend_next     = '0;
            end else if (is_space) begin
                // skip
            end else if (is_digit) begin
                start_next    = pos_reg;
                len_next      = P'(1);
                acc_next      = 64'(digit);
                head_next     = '0;
                too_long_next = 1'b0;
                mode_next     = MODE_NUM;
            end else if (is_letter) begin
                start_next    = pos_reg;
                len_next      = P'(1);
                acc_next      = '0;
                head_next     = {c, 40'd0};
                too_long_next = 1'b0;
                mode_next     = MODE_IDENT;
            end else if (is_lead) begin
                start_next    = pos_reg;
                len_next      = P'(1);
                acc_next      = '0;
                head_next     = '0;
                too_long_next = 1'b0;
                pend_next     = c;
                mode_next     = MODE_OP;
            end else if (is_punct) begin
                e1_valid = 1'b1;
                e1.kind  = KIND_RES;
                e1.start = clamp_out(pos_reg);
                e1.len   = OUT_BITS'(1);
                e1.op    = {c, 8'd0};
            end else begin
                e1_valid  = 1'b1;
                e1.kind   = KIND_ERR;
                e1.start  = clamp_out(pos_reg);
                e1.len    = OUT_BITS'(1);
                mode_next = MODE_ERR;
            end
        end

        e0.last = !e1_valid;
        e1.last = 1'b1;
    end

    assign res_a  = e0_valid ? e0 : e1;
    assign push_n = 2'(e0_valid) + 2'(e1_valid);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            pos_reg      <= '0;
            start_reg    <= '0;
            len_reg      <= '0;
            acc_reg      <= '0;
            head_reg     <= '0;
            too_long_reg <= 1'b0;
            pend_reg     <= '0;
        end else if (s_accept) begin
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            len_reg      <= len_next;
            acc_reg      <= acc_next;
            head_reg     <= head_next;
            too_long_reg <= too_long_next;
            pend_reg     <= pend_next;
        end
    end

    // result queue
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (push_n != 2'd0) fifo_reg[wr_ptr_reg] <= res_a;
            if (push_n == 2'd2) fifo_reg[wr_ptr_reg + PTR_W'(1)] <= e1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_accept) wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            if (m_accept) rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_reg + (s_accept ? CNT_W'(push_n) : CNT_W'(0))
                       - CNT_W'(m_accept);
        end
    end

    assign m_tdata = {5'b00000,
                      fifo_reg[rd_ptr_reg].kw,
                      fifo_reg[rd_ptr_reg].op,
                      fifo_reg[rd_ptr_reg].num,
                      fifo_reg[rd_ptr_reg].len,
                      fifo_reg[rd_ptr_reg].start};
    assign m_tuser = fifo_reg[rd_ptr_reg].kind;
    assign m_tlast = fifo_reg[rd_ptr_reg].last;

endmodule

>>> hw/rtl/csl_checker.sv
// Port checker for the C subset lexer, bound to c_subset_lexer.
// Depends on csl_pkg.
module csl_checker
    import csl_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_BITS-1:0] m_tdata,
    input logic [2:0]            m_tuser,
    input logic                  m_tlast
);

    logic [2:0]  kind;
    logic [63:0] num;
    logic [15:0] op;
    logic [2:0]  kw;

    assign kind = m_tuser;
    assign num  = m_tdata[103:40];
    assign op   = m_tdata[119:104];
    assign kw   = m_tdata[122:120];

    // no results may be queued right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result item shown after reset");

    // the end token is always the final item of its byte
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kind == KIND_END |-> m_tlast)
        else $error("end token without tlast");

    // only number tokens carry a value
    a_num_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kind != KIND_NUM |-> num == 64'd0)
        else $error("value on a non-number token");

    // a keyword is a reserved token without operator text
    a_kw_res: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kw != KW_NONE |-> kind == KIND_RES && op == 16'd0)
        else $error("keyword index on a wrong token");

    // a stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result item changed");

endmodule

bind c_subset_lexer csl_checker u_csl_checker (.*);

>>> dv/c_subset_lexer_tb.sv
// Self-checking testbench for the C subset lexer: streams random and directed source text
// through the s_ channel and checks every token on the m_ channel against a local lexer.
// Depends on csl_pkg and c_subset_lexer.
module c_subset_lexer_tb
    import csl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_NUM,
        SCAN_IDENT,
        SCAN_OP,
        SCAN_ERR
    } scan_mode_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;
    logic [2:0]            m_tuser;
    logic                  m_tlast;

    c_subset_lexer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    logic [7:0] text_q[$];          // bytes waiting to be sent
    result_t    expected_tokens[$];  // tokens predicted but not yet seen
    int         mismatch_count = 0;
    int         token_count = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    logic       in_taken = 1'b0;

    string      kw_names[5] = '{"return", "if", "else", "for", "while"};
    logic [2:0] kw_codes[5] = '{KW_RETURN, KW_IF, KW_ELSE, KW_FOR, KW_WHILE};
    string      letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string      word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string      lead_chars = "=!<>";

    // lexer state
    scan_mode_t  lex_mode = SCAN_IDLE;
    logic [19:0] lex_pos = '0;
    logic [19:0] tok_start = '0;
    logic [19:0] tok_len = '0;
    logic [63:0] num_acc = '0;
    logic [47:0] id_head = '0;
    logic        id_long = 1'b0;
    logic [7:0]  op_lead = '0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #400_000;
        $display("Mismatches found");
        $finish;
    end

    //------------------------------------------------------------------ lexer
    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [19:0] inc_sat(logic [19:0] v);
        return (v == '1) ? v : v + 20'd1;
    endfunction

    function automatic void add_token(logic [2:0] kind, logic [19:0] start, logic [19:0] len,
                                      logic [63:0] num, logic [15:0] op, logic [2:0] kw);
        result_t r;
        r.kind  = kind;
        r.start = start;
        r.len   = len;
        r.num   = num;
        r.op    = op;
        r.kw    = kw;
        r.last  = 1'b0;
        expected_tokens.push_back(r);
    endfunction

    function automatic void open_token();
        tok_start = lex_pos;
        tok_len   = 20'd1;
        num_acc   = '0;
        id_head   = '0;
        id_long   = 1'b0;
    endfunction

    function automatic void append_ident(logic [7:0] c);
        if (tok_len < 20'd6)
            id_head |= 48'(c) << (40 - 8 * tok_len);
        else
            id_long = 1'b1;
        tok_len = inc_sat(tok_len);
    endfunction

    function automatic logic [2:0] keyword_code();
        logic [47:0] kw_txt;
        if (id_long)
            return KW_NONE;
        for (int k = 0; k < 5; k++) begin
            kw_txt = '0;
            if (tok_len != kw_names[k].len())
                continue;
            for (int i = 0; i < kw_names[k].len(); i++)
                kw_txt |= 48'(kw_names[k][i]) << (40 - 8 * i);
            if (kw_txt == id_head)
                return kw_codes[k];
        end
        return KW_NONE;
    endfunction

    function automatic void lex_byte(logic [7:0] c);
        int         first;
        bit         used;
        bit         ended;
        logic [2:0] kw;
        logic [3:0] d;
        first = expected_tokens.size();
        used  = 1'b0;
        ended = 1'b0;
        d     = 4'(c - "0");
        case (lex_mode)
            SCAN_ERR: used = (c != 8'h00);
            SCAN_NUM: begin
                if (is_digit(c)) begin
                    if (num_acc > NUM_LIMIT || (num_acc == NUM_LIMIT && d > 4'd5))
                        num_acc = '1;
                    else
                        num_acc = num_acc * 64'd10 + 64'(d);
                    tok_len = inc_sat(tok_len);
                    used = 1'b1;
                end else begin
                    add_token(KIND_NUM, tok_start, tok_len, num_acc, '0, KW_NONE);
                    lex_mode = SCAN_IDLE;
                end
            end
            SCAN_IDENT: begin
                if (is_letter(c) || is_digit(c)) begin
                    append_ident(c);
                    used = 1'b1;
                end else begin
                    kw = keyword_code();
                    add_token((kw != KW_NONE) ? KIND_RES : KIND_IDENT, tok_start, tok_len,
                              '0, '0, kw);
                    lex_mode = SCAN_IDLE;
                end
            end
            SCAN_OP: begin
                // '=' completes a two-byte operator, anything else leaves the lead alone
                if (c == "=") begin
                    add_token(KIND_RES, tok_start, 20'd2, '0, {op_lead, c}, KW_NONE);
                    used = 1'b1;
                end else begin
                    add_token(KIND_RES, tok_start, 20'd1, '0, {op_lead, 8'h00}, KW_NONE);
                end
                op_lead  = '0;
                lex_mode = SCAN_IDLE;
            end
            default: ;
        endcase

        if (!used) begin
            if (c == 8'h00) begin
                add_token(KIND_END, lex_pos, '0, '0, '0, KW_NONE);
                ended = 1'b1;
            end else if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
                // skip whitespace
            end else if (is_digit(c)) begin
                open_token();
                num_acc  = 64'(d);
                lex_mode = SCAN_NUM;
            end else if (is_letter(c)) begin
                open_token();
                tok_len = '0;
                append_ident(c);
                lex_mode = SCAN_IDENT;
            end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
                open_token();
                op_lead  = c;
                lex_mode = SCAN_OP;
            end else if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                         (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126)) begin
                add_token(KIND_RES, lex_pos, 20'd1, '0, {c, 8'h00}, KW_NONE);
            end else begin
                add_token(KIND_ERR, lex_pos, 20'd1, '0, '0, KW_NONE);
                lex_mode = SCAN_ERR;
            end
        end

        if (ended) begin
            // end of text: restart everything for the next text
            lex_mode  = SCAN_IDLE;
            lex_pos   = '0;
            tok_start = '0;
            tok_len   = '0;
            num_acc   = '0;
            id_head   = '0;
            id_long   = 1'b0;
            op_lead   = '0;
        end else begin
            lex_pos = inc_sat(lex_pos);
        end
        if (expected_tokens.size() > first)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    //------------------------------------------------------------- text source
    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] bad_byte();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(1, 8));
            1: return 8'($urandom_range(14, 31));
            2: return 8'd127;
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic void push_token();
        int    pick;
        int    n;
        string s;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            push_text(kw_names[$urandom_range(0, 4)]);
        end else if (pick < 25) begin
            // near misses of keywords
            s = kw_names[$urandom_range(0, 4)];
            case ($urandom_range(0, 2))
                0: begin
                    n = $urandom_range(0, 62);
                    s = {s, word_chars.substr(n, n)};
                end
                1: s = s.substr(0, s.len() - 2);
                default: s[0] = s[0] - 8'd32;
            endcase
            push_text(s);
        end else if (pick < 45) begin
            n = $urandom_range(1, 10);
            text_q.push_back(letters[$urandom_range(0, 52)]);
            for (int i = 1; i < n; i++)
                text_q.push_back(word_chars[$urandom_range(0, 62)]);
        end else if (pick < 65) begin
            case ($urandom_range(0, 19))
                0: push_text("18446744073709551615");
                1: push_text("18446744073709551616");
                2, 3: n = $urandom_range(19, 24);
                default: n = $urandom_range(1, 6);
            endcase
            for (int i = 0; i < n; i++)
                text_q.push_back(8'($urandom_range("0", "9")));
        end else if (pick < 85) begin
            text_q.push_back(lead_chars[$urandom_range(0, 3)]);
            if ($urandom_range(0, 9) < 6)
                text_q.push_back("=");
        end else begin
            case ($urandom_range(0, 3))
                0: text_q.push_back(8'($urandom_range(33, 47)));
                1: text_q.push_back(8'($urandom_range(58, 64)));
                2: text_q.push_back(8'($urandom_range(91, 96)));
                default: text_q.push_back(8'($urandom_range(123, 126)));
            endcase
        end
    endfunction

    function automatic void push_random_text();
        int n;
        n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++) begin
            push_token();
            if ($urandom_range(0, 2) != 0) begin
                repeat ($urandom_range(1, 3)) begin
                    text_q.push_back(($urandom_range(0, 5) == 5) ? 8'd32
                                     : 8'($urandom_range(9, 13)));
                end
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            text_q.push_back(bad_byte());
            repeat ($urandom_range(0, 3))
                text_q.push_back(8'($urandom_range(1, 255)));
        end
        text_q.push_back(8'h00);
    endfunction

    //---------------------------------------------------------- driver / monitor
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            // hold the item until it is taken
        end else if (text_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            s_tvalid <= 1'b1;
            s_tdata  <= text_q.pop_front();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                lex_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                seen.kind  = m_tuser;
                seen.start = m_tdata[19:0];
                seen.len   = m_tdata[39:20];
                seen.num   = m_tdata[103:40];
                seen.op    = m_tdata[119:104];
                seen.kw    = m_tdata[122:120];
                seen.last  = m_tlast;
                if (expected_tokens.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("token %0d arrived with none predicted: kind %0d start %0d",
                                 token_count, seen.kind, seen.start);
                end else begin
                    want = expected_tokens.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("token %0d expected kind %0d start %0d len %0d num %0d",
                                     token_count, want.kind, want.start, want.len, want.num);
                            $display("    expected op %h kw %0d last %0b",
                                     want.op, want.kw, want.last);
                            $display("token %0d      got kind %0d start %0d len %0d num %0d",
                                     token_count, seen.kind, seen.start, seen.len, seen.num);
                            $display("         got op %h kw %0d last %0b",
                                     seen.op, seen.kw, seen.last);
                        end
                    end
                end
                token_count++;
            end
        end
    end

    //----------------------------------------------------------------- sequence
    int sender_idle[4]    = '{0, 50, 0, 16};
    int receiver_stall[4] = '{0, 0, 50, 16};

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            idle_pct  = sender_idle[p];
            stall_pct = receiver_stall[p];
            if (p == 0) begin
                // keywords, digit then letter, pairs, lone leads, error then ignored bytes,
                // empty text
                push_text("else 7e== if a_1<=99!x;>");
                text_q.push_back(8'hFF);
                text_q.push_back("q");
                text_q.push_back(8'h00);
                text_q.push_back(8'h00);
            end
            while (text_q.size() < 125)
                push_random_text();
            while (text_q.size() != 0 || s_tvalid)
                @(negedge aclk);
        end
        idle_pct  = 0;
        stall_pct = 0;
        for (int w = 0; w < 10_000 && expected_tokens.size() != 0; w++)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
        mismatch_count += expected_tokens.size();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> c_subset_lexer.f
hw/rtl/csl_pkg.sv
hw/rtl/c_subset_lexer.sv
hw/rtl/csl_checker.sv
dv/c_subset_lexer_tb.sv
